// ===== design/rpd_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the distance ranker.
package rpd_pkg;

    // Table size and coordinate width.
    localparam int MAX_CANDIDATES = 16;
    localparam int COORD_BITS     = 16;

    // Fixed field widths of the stream items.
    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 5;
    localparam int RESULT_LIMIT = 16;

    // Derived sizes.
    localparam int N_LIMIT = (MAX_CANDIDATES < RESULT_LIMIT) ? MAX_CANDIDATES : RESULT_LIMIT;
    localparam int CNT_W   = $clog2(N_LIMIT + 1);
    localparam int ADDR_W  = $clog2(MAX_CANDIDATES);
    localparam int TBL_W   = $clog2(MAX_CANDIDATES + 1) + 1;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DIST_W  = 2 * DIFF_W;

    // Input item kinds carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_W-1:0]            dist_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch_voter;
        logic              load_write;
        logic [ADDR_W-1:0] load_slot;
        logic              clear_list;
        logic              issue_valid;
        idx_t              issue_idx;
        logic              shift_out;
    } rpd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cnt_t list_count;
        idx_t head_index;
    } rpd_status_t;

    // Input coordinate field kept in COORD_BITS bits, two's complement.
    function automatic coord_t to_coord(input logic signed [FIELD_W-1:0] field);
        to_coord = coord_t'(field);
    endfunction

endpackage

// ===== design/rpd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module rpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rpd_datapath.sv =====
// Datapath: candidate table, distance pipeline and sorted insertion list.
module rpd_datapath import rpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rpd_cmd_t    cmd,
    input  coord_t      in_x,
    input  coord_t      in_y,
    output rpd_status_t status
);

    logic [2*COORD_BITS-1:0] rd_data;

    // Voter point of the current query.
    coord_t voter_x_reg;
    coord_t voter_y_reg;

    // Pipeline valid bits and candidate indices.
    logic rd_valid_reg, diff_valid_reg, sq_valid_reg, dist_valid_reg;
    idx_t rd_idx_reg, diff_idx_reg, sq_idx_reg, dist_idx_reg;

    // Pipeline payload.
    logic signed [DIFF_W-1:0]   dx_reg, dy_reg;
    logic signed [2*DIFF_W-1:0] sqx_reg, sqy_reg;
    dist_t                      dist_reg;

    // Sorted list, nearest first.
    dist_t list_dist_reg [N_LIMIT];
    idx_t  list_idx_reg  [N_LIMIT];
    dist_t list_dist_next [N_LIMIT];
    idx_t  list_idx_next  [N_LIMIT];
    cnt_t  count_reg, count_next;
    logic  greater [N_LIMIT];

    coord_t cand_x, cand_y;

    // Candidate table, x in the low half and y in the high half.
    rpd_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_CANDIDATES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.load_write),
        .wr_addr (cmd.load_slot),
        .wr_data ({in_y, in_x}),
        .rd_en   (cmd.issue_valid),
        .rd_addr (ADDR_W'(cmd.issue_idx)),
        .rd_data (rd_data)
    );

    assign cand_x = coord_t'(rd_data[COORD_BITS-1:0]);
    assign cand_y = coord_t'(rd_data[2*COORD_BITS-1:COORD_BITS]);

    // Voter capture on every accepted input transaction.
    always_ff @(posedge aclk) begin
        if (cmd.latch_voter) begin
            voter_x_reg <= in_x;
            voter_y_reg <= in_y;
        end
    end

    // Valid bits of the distance pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.issue_valid;
            diff_valid_reg <= rd_valid_reg;
            sq_valid_reg   <= diff_valid_reg;
            dist_valid_reg <= sq_valid_reg;
        end
    end

    // Differences, squares and sum, one register stage each.
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= cmd.issue_idx;
        diff_idx_reg <= rd_idx_reg;
        sq_idx_reg   <= diff_idx_reg;
        dist_idx_reg <= sq_idx_reg;
        dx_reg   <= DIFF_W'(voter_x_reg) - DIFF_W'(cand_x);
        dy_reg   <= DIFF_W'(voter_y_reg) - DIFF_W'(cand_y);
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        dist_reg <= dist_t'(sqx_reg) + dist_t'(sqy_reg);
    end

    // Insertion of the new distance behind every entry that is not farther.
    // Candidates arrive in index order, so equal distances keep the lower index first.
    always_comb begin
        for (int k = 0; k < N_LIMIT; k++) begin
            greater[k] = (CNT_W'(k) < count_reg) && (list_dist_reg[k] > dist_reg);
        end
        for (int k = 0; k < N_LIMIT; k++) begin
            list_dist_next[k] = list_dist_reg[k];
            list_idx_next[k]  = list_idx_reg[k];
        end
        count_next = count_reg;
        if (cmd.clear_list) begin
            count_next = '0;
        end else if (dist_valid_reg) begin
            for (int k = 0; k < N_LIMIT; k++) begin
                if (k > 0 && greater[(k > 0) ? k - 1 : 0]) begin
                    list_dist_next[k] = list_dist_reg[(k > 0) ? k - 1 : 0];
                    list_idx_next[k]  = list_idx_reg[(k > 0) ? k - 1 : 0];
                end else if (greater[k] || CNT_W'(k) == count_reg) begin
                    list_dist_next[k] = dist_reg;
                    list_idx_next[k]  = dist_idx_reg;
                end
            end
            count_next = count_reg + 1'b1;
        end else if (cmd.shift_out) begin
            for (int k = 0; k < N_LIMIT - 1; k++) begin
                list_dist_next[k] = list_dist_reg[k+1];
                list_idx_next[k]  = list_idx_reg[k+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    // List registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N_LIMIT; k++) begin
            list_dist_reg[k] <= list_dist_next[k];
            list_idx_reg[k]  <= list_idx_next[k];
        end
    end

    assign status.list_count = count_reg;
    assign status.head_index = list_idx_reg[0];

endmodule

// ===== design/rpd_ctrl.sv =====
// Controller: configuration register, sequencing state machine and result counters.
module rpd_ctrl import rpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_opcode,
    input  logic [SLOT_W-1:0] in_slot,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output idx_t              out_rank,
    output logic              out_last,
    output rpd_cmd_t          cmd,
    input  rpd_status_t       status
);

    logic [CFG_W-1:0] active_reg;
    state_t           state_reg, state_next;
    cnt_t             issue_cnt_reg, issue_cnt_next;
    cnt_t             emit_cnt_reg, emit_cnt_next;
    cnt_t             n_used;
    cnt_t             n_last;
    logic             in_accept;
    logic             slot_ok;

    // Configuration register, always ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= CFG_W'(RESULT_LIMIT);
        end else if (cfg_valid) begin
            active_reg <= cfg_data;
        end
    end

    // Candidate count limited to the range the table supports.
    always_comb begin
        priority if (active_reg == '0) begin
            n_used = CNT_W'(1);
        end else if (active_reg > CFG_W'(N_LIMIT)) begin
            n_used = CNT_W'(N_LIMIT);
        end else begin
            n_used = CNT_W'(active_reg);
        end
    end

    assign n_last    = n_used - 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign slot_ok   = TBL_W'(in_slot) < TBL_W'(MAX_CANDIDATES);

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        cmd.latch_voter = in_accept;
        cmd.load_write  = in_accept && (in_opcode == OP_LOAD) && slot_ok;
        cmd.load_slot   = ADDR_W'(in_slot);
        cmd.clear_list  = 1'b0;
        cmd.issue_valid = 1'b0;
        cmd.issue_idx   = idx_t'(issue_cnt_reg);
        cmd.shift_out   = 1'b0;
        out_valid       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_opcode == OP_QUERY) begin
                    cmd.clear_list = 1'b1;
                    issue_cnt_next = '0;
                    state_next     = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // One table read per candidate.
                cmd.issue_valid = 1'b1;
                if (issue_cnt_reg == n_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // Wait until every distance has been inserted.
                if (status.list_count == n_used) begin
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.shift_out = 1'b1;
                    if (emit_cnt_reg == n_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_cnt_next = emit_cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_rank = idx_t'(emit_cnt_reg);
    assign out_last = (emit_cnt_reg == n_last);

endmodule

// ===== design/rank_points_by_distance.sv =====
// Top level: ranks stored candidate points by squared distance to a voter point.
// A load transaction writes its point to the table slot when accepted. A query of N candidates
// issues N table reads, passes each through the read, difference, square and sum registers
// into the insertion list, then emits N results, each held while m_tready is low.
// One item is in work at a time, since the single insertion list holds one query's ranking.
// Reset (aresetn low, synchronous) sets the count to 16 and empties the list; the table is not.
module rank_points_by_distance import rpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: active_candidates.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[3:0], point_x[19:4], point_y[35:20], zero pad
    input  logic        s_tuser,   // opcode
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // candidate_index[3:0], rank_position[7:4]
    output logic        m_tlast    // last
);

    rpd_cmd_t    cmd;
    rpd_status_t status;
    idx_t        rank;
    coord_t      in_x, in_y;

    assign cfg_ready = 1'b1;

    // Input coordinates in table format.
    assign in_x = to_coord(s_tdata[19:4]);
    assign in_y = to_coord(s_tdata[35:20]);

    rpd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_slot   (s_tdata[3:0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rank  (rank),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    rpd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_x    (in_x),
        .in_y    (in_y),
        .status  (status)
    );

    // Result transaction payload.
    assign m_tdata = {rank, status.head_index};

endmodule
